/* src/gcm_pkg.sv */
// shared types and codes of the gradient color map
package gcm_pkg;

	localparam logic       FUNC_MAP       = 1'b0;
	localparam logic       FUNC_WRITE     = 1'b1;

	localparam logic [1:0] REG_RANGE_MIN  = 2'd0;
	localparam logic [1:0] REG_RANGE_MAX  = 2'd1;
	localparam logic [1:0] REG_STOP_COUNT = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef struct packed {
		logic               func;
		logic signed [31:0] sample;
		logic [2:0]         stop_index;
		logic [16:0]        stop_position;
		logic [7:0]         stop_red;
		logic [7:0]         stop_green;
		logic [7:0]         stop_blue;
		logic [7:0]         stop_alpha;
	} request_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       bad_range;
	} result_t;

endpackage

/* src/gcm_frac_div.sv */
// pipelined restoring divider for the normalized sample fraction
module gcm_frac_div #(
	parameter int FB = 16,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  logic [TW-1:0] tag_in,
	input  logic [31:0]   num,
	input  logic [31:0]   den,
	output logic          v_out,
	output logic [TW-1:0] tag_out,
	output logic [FB-1:0] quo
);

	logic          v_s   [FB];
	logic [TW-1:0] tag_s [FB];
	logic [31:0]   rem_s [FB];
	logic [31:0]   den_s [FB];
	logic [FB-1:0] quo_s [FB];

	logic [31:0]   r_in  [FB];
	logic [31:0]   d_in  [FB];
	logic [FB-1:0] q_in  [FB];
	logic [32:0]   sh    [FB];
	logic          take  [FB];

	always_comb begin
		for (int k = 0; k < FB; k++) begin
			if (k == 0) begin
				r_in[k] = num;
				d_in[k] = den;
				q_in[k] = '0;
			end else begin
				r_in[k] = rem_s[k-1];
				d_in[k] = den_s[k-1];
				q_in[k] = quo_s[k-1];
			end
			sh[k]   = {r_in[k], 1'b0};
			take[k] = sh[k] >= {1'b0, d_in[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FB; k++) v_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < FB; k++) v_s[k] <= (k == 0) ? v_in : v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < FB; k++) begin
			tag_s[k] <= (k == 0) ? tag_in : tag_s[k-1];
			den_s[k] <= d_in[k];
			rem_s[k] <= take[k] ? 32'(sh[k] - {1'b0, d_in[k]}) : sh[k][31:0];
			quo_s[k] <= {q_in[k][FB-2:0], take[k]};
		end
	end

	assign v_out   = v_s[FB-1];
	assign tag_out = tag_s[FB-1];
	assign quo     = quo_s[FB-1];

endmodule

/* src/gradient_color_map.sv */
// top level: piecewise linear rgba false color mapper
//
// channel   direction  handshake              payload
// request   in         start high, busy low   gcm_pkg::request_t
// result    out        done strobe, 1 cycle   gcm_pkg::result_t
// config    in         cfg_we                 cfg_index, cfg_data
//
// one request per cycle; busy stays low. a map request gives its result on done
// after passing every pipeline stage, among them the fraction divider
// (one quotient bit per stage) and the channel divider (eight stages).
// stop writes take effect in the table lookup stage, in request order.
// reset clears the pipeline valid bits and the configuration registers, not the stop table.
module gradient_color_map #(
	parameter int MAX_STOPS     = 8,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  gcm_pkg::request_t                request,
	output logic                             done,
	output gcm_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [gcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PW = POS_FRAC_BITS + 1;
	localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int NW = $clog2(MAX_STOPS + 1);
	localparam int MW = PW + 8;
	localparam int SW = PW + 9;
	localparam logic [PW-1:0] ONE = PW'(1) << POS_FRAC_BITS;

	typedef struct packed {
		logic          wr;
		logic [2:0]    idx;
		logic [PW-1:0] pos;
		logic [31:0]   color;
		logic          neg;
		logic          ge;
	} tag_t;

	typedef struct packed {
		logic [PW-1:0] pos;
		logic [31:0]   color;
	} stop_t;

	// configuration
	logic signed [31:0] range_min_q, range_max_q;
	logic [3:0]         stop_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q  <= 32'sd0;
			range_max_q  <= 32'sd65535;
			stop_count_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcm_pkg::REG_RANGE_MIN:  range_min_q  <= cfg_data;
				gcm_pkg::REG_RANGE_MAX:  range_max_q  <= cfg_data;
				gcm_pkg::REG_STOP_COUNT: stop_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	logic          bad;
	logic [NW-1:0] n_stops;

	assign bad     = range_max_q <= range_min_q;
	assign n_stops = (int'(stop_count_q) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(stop_count_q);
	assign busy    = 1'b0;

	// s1: accept
	logic              v_s1;
	gcm_pkg::request_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	// s2: offsets
	logic               v_s2;
	tag_t               tag_s2;
	logic signed [32:0] num_s2, den_s2;
	logic [24:0]        pos_wide;
	tag_t               tag_s1;

	always_comb begin
		pos_wide     = 25'(req_s1.stop_position);
		tag_s1.wr    = req_s1.func == gcm_pkg::FUNC_WRITE;
		tag_s1.idx   = req_s1.stop_index;
		tag_s1.pos   = (pos_wide > 25'(ONE)) ? ONE : pos_wide[PW-1:0];
		tag_s1.color = {req_s1.stop_alpha, req_s1.stop_red, req_s1.stop_green,
			req_s1.stop_blue};
		tag_s1.neg   = 1'b0;
		tag_s1.ge    = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		num_s2 <= {req_s1.sample[31], req_s1.sample} - {range_min_q[31], range_min_q};
		den_s2 <= {range_max_q[31], range_max_q} - {range_min_q[31], range_min_q};
	end

	// fraction divider
	tag_t                   div_tag_in, div_tag_out;
	logic                   div_v_out;
	logic [POS_FRAC_BITS-1:0] div_quo;

	always_comb begin
		div_tag_in     = tag_s2;
		div_tag_in.neg = num_s2 <= 33'sd0;
		div_tag_in.ge  = num_s2 >= den_s2;
	end

	gcm_frac_div #(
		.FB (POS_FRAC_BITS),
		.TW ($bits(tag_t))
	) u_frac_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (v_s2),
		.tag_in  (div_tag_in),
		.num     (num_s2[31:0]),
		.den     (den_s2[31:0]),
		.v_out   (div_v_out),
		.tag_out (div_tag_out),
		.quo     (div_quo)
	);

	// s3: fraction, stop lookup and table write
	logic          v_s3;
	tag_t          tag_s3;
	logic [PW-1:0] frac_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= div_v_out;
	end

	always_ff @(posedge clk) begin
		tag_s3  <= div_tag_out;
		frac_s3 <= div_tag_out.ge ? ONE :
			(div_tag_out.neg ? '0 : {1'b0, div_quo});
	end

	logic [PW-1:0] pos_q [MAX_STOPS];
	stop_t         stop_mem_q [MAX_STOPS];
	logic          wr_en;
	logic [AW-1:0] wr_addr;

	assign wr_en   = v_s3 && tag_s3.wr && (int'(tag_s3.idx) < MAX_STOPS);
	assign wr_addr = AW'(tag_s3.idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_q[wr_addr]      <= tag_s3.pos;
			stop_mem_q[wr_addr] <= '{pos: tag_s3.pos, color: tag_s3.color};
		end
	end

	logic [MAX_STOPS-1:0] hit, eq, first;
	logic [AW-1:0]        idx_enc, addr_b, addr_a;
	logic                 exact;

	always_comb begin
		for (int i = 0; i < MAX_STOPS; i++) begin
			hit[i] = ((i == 0) || (i < int'(n_stops))) && (pos_q[i] >= frac_s3);
			eq[i]  = pos_q[i] == frac_s3;
		end
		first   = hit & (~hit + MAX_STOPS'(1));
		idx_enc = '0;
		for (int i = 0; i < MAX_STOPS; i++) begin
			if (first[i]) idx_enc = idx_enc | AW'(i);
		end
		exact = bad || !(|hit) || first[0] || (|(first & eq));
		if (bad)        addr_b = '0;
		else if (!(|hit)) addr_b = AW'(n_stops - NW'(1));
		else            addr_b = idx_enc;
		addr_a = exact ? addr_b : addr_b - AW'(1);
	end

	// s4: addresses
	logic          v_s4, exact_s4, zero_s4, bad_s4;
	logic [AW-1:0] addr_a_s4, addr_b_s4;
	logic [PW-1:0] frac_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3 && !tag_s3.wr;
	end

	always_ff @(posedge clk) begin
		addr_a_s4 <= addr_a;
		addr_b_s4 <= addr_b;
		exact_s4  <= exact;
		frac_s4   <= frac_s3;
		zero_s4   <= n_stops == '0;
		bad_s4    <= bad;
	end

	// s5: table read
	logic          v_s5, exact_s5, zero_s5, bad_s5;
	stop_t         rd_a_s5, rd_b_s5;
	logic [PW-1:0] frac_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		rd_a_s5  <= stop_mem_q[addr_a_s4];
		rd_b_s5  <= stop_mem_q[addr_b_s4];
		exact_s5 <= exact_s4;
		frac_s5  <= frac_s4;
		zero_s5  <= zero_s4;
		bad_s5   <= bad_s4;
	end

	// s6: weights
	logic          v_s6, zero_s6, bad_s6;
	logic [PW-1:0] w0_s6, w1_s6, dist_s6;
	logic [31:0]   c0_s6, c1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (exact_s5) begin
			w0_s6   <= '0;
			w1_s6   <= PW'(1);
			dist_s6 <= PW'(1);
		end else begin
			w0_s6   <= rd_b_s5.pos - frac_s5;
			w1_s6   <= frac_s5 - rd_a_s5.pos;
			dist_s6 <= rd_b_s5.pos - rd_a_s5.pos;
		end
		c0_s6   <= rd_a_s5.color;
		c1_s6   <= rd_b_s5.color;
		zero_s6 <= zero_s5;
		bad_s6  <= bad_s5;
	end

	// s7: products, channel 0 red, 1 green, 2 blue, 3 alpha
	logic          v_s7, zero_s7, bad_s7;
	logic [PW-1:0] dist_s7;
	logic [MW-1:0] p0_s7 [4];
	logic [MW-1:0] p1_s7 [4];
	logic [7:0]    ch0 [4];
	logic [7:0]    ch1 [4];

	always_comb begin
		ch0[0] = c0_s6[23:16];
		ch0[1] = c0_s6[15:8];
		ch0[2] = c0_s6[7:0];
		ch0[3] = c0_s6[31:24];
		ch1[0] = c1_s6[23:16];
		ch1[1] = c1_s6[15:8];
		ch1[2] = c1_s6[7:0];
		ch1[3] = c1_s6[31:24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			p0_s7[c] <= MW'(ch0[c]) * MW'(w0_s6);
			p1_s7[c] <= MW'(ch1[c]) * MW'(w1_s6);
		end
		dist_s7 <= dist_s6;
		zero_s7 <= zero_s6;
		bad_s7  <= bad_s6;
	end

	// s8: sums
	logic          v_s8, zero_s8, bad_s8;
	logic [PW-1:0] dist_s8;
	logic [SW-1:0] sum_s8 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else         v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) sum_s8[c] <= SW'(p0_s7[c]) + SW'(p1_s7[c]);
		dist_s8 <= dist_s7;
		zero_s8 <= zero_s7;
		bad_s8  <= bad_s7;
	end

	// channel divider, one quotient bit per stage
	logic          v_sd    [8];
	logic          zero_sd [8];
	logic          bad_sd  [8];
	logic [PW-1:0] dist_sd [8];
	logic [PW-1:0] rem_sd  [8][4];
	logic [7:0]    low_sd  [8][4];
	logic [7:0]    quo_sd  [8][4];

	logic [PW-1:0] r_in   [8][4];
	logic [7:0]    l_in   [8][4];
	logic [7:0]    q_in   [8][4];
	logic [PW-1:0] d_in   [8];
	logic [PW:0]   t_sh   [8][4];
	logic          take   [8][4];

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			d_in[j] = (j == 0) ? dist_s8 : dist_sd[j-1];
			for (int c = 0; c < 4; c++) begin
				if (j == 0) begin
					r_in[j][c] = sum_s8[c][SW-2:8];
					l_in[j][c] = sum_s8[c][7:0];
					q_in[j][c] = '0;
				end else begin
					r_in[j][c] = rem_sd[j-1][c];
					l_in[j][c] = low_sd[j-1][c];
					q_in[j][c] = quo_sd[j-1][c];
				end
				t_sh[j][c] = {r_in[j][c], l_in[j][c][7]};
				take[j][c] = t_sh[j][c] >= {1'b0, d_in[j]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) v_sd[j] <= 1'b0;
		end else begin
			for (int j = 0; j < 8; j++) v_sd[j] <= (j == 0) ? v_s8 : v_sd[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 8; j++) begin
			dist_sd[j] <= d_in[j];
			zero_sd[j] <= (j == 0) ? zero_s8 : zero_sd[j-1];
			bad_sd[j]  <= (j == 0) ? bad_s8 : bad_sd[j-1];
			for (int c = 0; c < 4; c++) begin
				rem_sd[j][c] <= take[j][c] ? PW'(t_sh[j][c] - {1'b0, d_in[j]}) :
					t_sh[j][c][PW-1:0];
				low_sd[j][c] <= {l_in[j][c][6:0], 1'b0};
				quo_sd[j][c] <= {q_in[j][c][6:0], take[j][c]};
			end
		end
	end

	// output register
	logic             done_q;
	gcm_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_sd[7];
	end

	always_ff @(posedge clk) begin
		result_q.red       <= zero_sd[7] ? 8'd0 : quo_sd[7][0];
		result_q.green     <= zero_sd[7] ? 8'd0 : quo_sd[7][1];
		result_q.blue      <= zero_sd[7] ? 8'd0 : quo_sd[7][2];
		result_q.alpha     <= zero_sd[7] ? 8'd0 : quo_sd[7][3];
		result_q.bad_range <= bad_sd[7];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* src/gcm_checker.sv */
// port level checker for the gradient color map, with its bind
module gcm_checker #(
	parameter int POS_FRAC_BITS = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input gcm_pkg::request_t               request,
	input logic                            done,
	input gcm_pkg::result_t                result,
	input logic                            cfg_we,
	input logic [gcm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [gcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int LAT = POS_FRAC_BITS + 17;

	logic signed [31:0] min_q, max_q;
	logic [3:0]         count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= 32'sd0;
			max_q   <= 32'sd65535;
			count_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcm_pkg::REG_RANGE_MIN:  min_q   <= cfg_data;
				gcm_pkg::REG_RANGE_MAX:  max_q   <= cfg_data;
				gcm_pkg::REG_STOP_COUNT: count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && request.func == gcm_pkg::FUNC_MAP, LAT))
		else $error("result without a map request");

	a_bad_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.bad_range == (max_q <= min_q))
		else $error("bad_range does not match the range");

	a_no_stops: assert property (@(posedge clk) disable iff (!arst_n)
		done && count_q == 4'd0 |-> result.red == 8'd0 && result.green == 8'd0 &&
			result.blue == 8'd0 && result.alpha == 8'd0)
		else $error("color given with an empty table");

endmodule

bind gradient_color_map gcm_checker #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_gcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.request   (request),
	.done      (done),
	.result    (result),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
